// ===== design/detok_pkg.sv =====
package detok_pkg;

    localparam int NUM_TOK   = 141;
    localparam int TOK_CHARS = 7;
    localparam int OPND_BASE = 103;

    localparam logic [7:0] FIRST_BASE = 8'h80;
    localparam logic [7:0] FIRST_TOP  = 8'hE6;
    localparam logic [7:0] RAW_CODE   = 8'd16;
    localparam logic [7:0] SPACE_CODE = 8'hFF;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NL      = 8'd10;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_QUOTE   = 8'd34;
    localparam logic [7:0] CH_SEMI    = 8'd59;

    // token text entry: length in the top bits, text right aligned below
    typedef logic [58:0] t_ent;
    typedef t_ent t_rom [NUM_TOK];

    typedef struct packed {
        logic       err;
        logic [3:0] sp_cnt;
        logic       lit_en;
        logic [7:0] lit_ch;
        logic       tab_pre;
        logic       tok_en;
        logic       tab_post;
        logic       quo;
        logic       nl;
    } t_job;

    typedef struct packed {
        logic       load;
        logic [7:0] tok_idx;
        t_job       job;
    } t_load;

    function automatic logic job_empty(input t_job j);
        return !(j.err || (j.sp_cnt != 4'd0) || j.lit_en || j.tab_pre || j.tok_en
                 || j.tab_post || j.quo || j.nl);
    endfunction

    function automatic logic [55:0] tok_text(input logic [7:0] idx);
        logic [55:0] s;
        s = '0;
        unique case (idx)
            8'd0:   s = "INCLUDE"; 8'd1:   s = "INCBIN";  8'd2:   s = "MACRO";
            8'd3:   s = "LOCAL";   8'd4:   s = "RLCA";    8'd5:   s = "RRCA";
            8'd6:   s = "HALT";    8'd7:   s = "CALL";    8'd8:   s = "PUSH";
            8'd9:   s = "RETN";    8'd10:  s = "RETI";    8'd11:  s = "DJNZ";
            8'd12:  s = "OUTI";    8'd13:  s = "OUTD";    8'd14:  s = "LDIR";
            8'd15:  s = "CPIR";    8'd16:  s = "INIR";    8'd17:  s = "OTIR";
            8'd18:  s = "LDDR";    8'd19:  s = "CPDR";    8'd20:  s = "INDR";
            8'd21:  s = "OTDR";    8'd22:  s = "DD";      8'd23:  s = "DEFB";
            8'd24:  s = "DEFW";    8'd25:  s = "DEFS";    8'd26:  s = "DISP";
            8'd27:  s = "ENDM";    8'd28:  s = "EDUP";    8'd29:  s = "ENDL";
            8'd30:  s = "MAIN";    8'd31:  s = "ELSE";    8'd32:  s = "DISPLAY";
            8'd33:  s = "EXA";     8'd34:  s = "DB";      8'd35:  s = "DW";
            8'd36:  s = "DS";      8'd37:  s = "NOP";     8'd38:  s = "INC";
            8'd39:  s = "DEC";     8'd40:  s = "RLA";     8'd41:  s = "RRA";
            8'd42:  s = "DAA";     8'd43:  s = "CPL";     8'd44:  s = "SCF";
            8'd45:  s = "CCF";     8'd46:  s = "ADD";     8'd47:  s = "ADC";
            8'd48:  s = "SUB";     8'd49:  s = "SBC";     8'd50:  s = "AND";
            8'd51:  s = "XOR";     8'd52:  s = "RET";     8'd53:  s = "POP";
            8'd54:  s = "RST";     8'd55:  s = "EXX";     8'd56:  s = "RLC";
            8'd57:  s = "RRC";     8'd58:  s = "SLA";     8'd59:  s = "SRA";
            8'd60:  s = "SLI";     8'd61:  s = "SRL";     8'd62:  s = "BIT";
            8'd63:  s = "RES";     8'd64:  s = "SET";     8'd65:  s = "OUT";
            8'd66:  s = "NEG";     8'd67:  s = "RRD";     8'd68:  s = "RLD";
            8'd69:  s = "LDI";     8'd70:  s = "CPI";     8'd71:  s = "INI";
            8'd72:  s = "LDD";     8'd73:  s = "CPD";     8'd74:  s = "IND";
            8'd75:  s = "ORG";     8'd76:  s = "EQU";     8'd77:  s = "ENT";
            8'd78:  s = "INF";     8'd79:  s = "DUP";     8'd80:  s = "IFN";
            8'd81:  s = "REPEAT";  8'd82:  s = "UNTIL0";  8'd83:  s = "IF0";
            8'd84:  s = "LD";      8'd85:  s = "JR";      8'd86:  s = "JP";
            8'd87:  s = "OR";      8'd88:  s = "CP";      8'd89:  s = "EX";
            8'd90:  s = "DI";      8'd91:  s = "EI";      8'd92:  s = "IN";
            8'd93:  s = "RL";      8'd94:  s = "RR";      8'd95:  s = "IM";
            8'd96:  s = "ENDIF";   8'd97:  s = "EXD";     8'd98:  s = "JR\tNZ,";
            8'd99:  s = "JR\tZ,";  8'd100: s = "JR\tNC,"; 8'd101: s = "JR\tC,";
            8'd102: s = "RUN";
            8'd103: s = "(BC)";    8'd104: s = "(DE)";    8'd105: s = "(HL)";
            8'd106: s = "(SP)";    8'd107: s = "(IX)";    8'd108: s = "(IY)";
            8'd109: s = "(C)";     8'd110: s = "(IX";     8'd111: s = "(IY";
            8'd112: s = "AF'";     8'd113: s = "BC";      8'd114: s = "DE";
            8'd115: s = "HL";      8'd116: s = "AF";      8'd117: s = "IX";
            8'd118: s = "IY";      8'd119: s = "SP";      8'd120: s = "NZ";
            8'd121: s = "NC";      8'd122: s = "PO";      8'd123: s = "PE";
            8'd124: s = "HX";      8'd125: s = "LX";      8'd126: s = "HY";
            8'd127: s = "LY";      8'd128: s = "B";       8'd129: s = "C";
            8'd130: s = "D";       8'd131: s = "E";       8'd132: s = "H";
            8'd133: s = "L";       8'd134: s = "A";       8'd135: s = "P";
            8'd136: s = "M";       8'd137: s = "Z";       8'd138: s = "R";
            8'd139: s = "I";       8'd140: s = " ";
            default: s = '0;
        endcase
        return s;
    endfunction

    function automatic t_rom init_rom();
        t_rom r;
        logic [55:0] s;
        logic [2:0]  n;
        for (int i = 0; i < NUM_TOK; i++) begin
            s = tok_text(i[7:0]);
            n = 3'd0;
            for (int k = 0; k < TOK_CHARS; k++) begin
                if (s[k*8 +: 8] != 8'd0) n = n + 3'd1;
            end
            r[i] = {n, s};
        end
        return r;
    endfunction

    // operand token code to table row; bit 8 flags a known code
    function automatic logic [8:0] opnd_idx(input logic [7:0] b);
        logic [8:0] r;
        r = '0;
        unique case (b)
            8'h9F, 8'hA0, 8'hA1, 8'hA2, 8'hA3, 8'hA4:
                r = {1'b1, b - 8'h9F + 8'(OPND_BASE)};
            8'hD0, 8'hD1, 8'hD2, 8'hD3:
                r = {1'b1, b - 8'hD0 + 8'(OPND_BASE + 6)};
            8'hE0, 8'hE1, 8'hE2, 8'hE3, 8'hE4, 8'hE5, 8'hE6, 8'hE7, 8'hE8,
            8'hE9, 8'hEA, 8'hEB, 8'hEC, 8'hED, 8'hEE, 8'hEF, 8'hF0, 8'hF1,
            8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6, 8'hF7, 8'hF8, 8'hF9, 8'hFA:
                r = {1'b1, b - 8'hE0 + 8'(OPND_BASE + 10)};
            8'hFF:
                r = {1'b1, 8'(NUM_TOK - 1)};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/detok_if.sv =====
interface detok_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_req;
    modport source (output valid, output byte_req, input ready);
    modport sink   (input valid, input byte_req, output ready);
endinterface

interface detok_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_res;
    logic       error;
    logic       last;
    modport source (output valid, output char_res, output error, output last, input ready);
    modport sink   (input valid, input char_res, input error, input last, output ready);
endinterface

// ===== design/tokenized_asm_line_detokenizer_unit.sv =====
// Detokenizer for tokenized assembler lines. Feed body bytes on i_byte; plain
// text comes out on o_char one character per word, with last set on the final
// word a byte causes. A byte is taken when no word is pending or in the cycle
// the last word of the previous byte leaves, so bytes that yield one character
// (or none) go back to back while o_char is ready. The single output expander
// reads a token's text from the token memory once at accept and then walks it
// out one character a cycle while o_char is ready; the next byte waits for its
// last word. An unknown token gives one word with error set and the block then
// swallows every byte without output until reset.
module tokenized_asm_line_detokenizer_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    detok_byte_if.sink    i_byte,
    detok_char_if.source  o_char
);
    import detok_pkg::*;

    t_load load;
    logic  accept;

    // a byte enters only when the expander is free or finishing
    assign accept = i_byte.valid && i_byte.ready;

    detok_ctl u_ctl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_byte.byte_req),
        .o_load   (load)
    );

    detok_exp u_exp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .o_ready  (i_byte.ready),
        .o_valid  (o_char.valid),
        .i_ready  (o_char.ready),
        .o_char   (o_char.char_res),
        .o_error  (o_char.error),
        .o_last   (o_char.last)
    );

endmodule

// ===== design/detok_ctl.sv =====
module detok_ctl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_byte,
    output detok_pkg::t_load     o_load
);
    import detok_pkg::*;

    logic       r_expect, n_expect;
    logic [7:0] r_left, n_left;
    logic       r_cmt, n_cmt;
    logic       r_quo, n_quo;
    logic       r_raw, n_raw;
    logic [1:0] r_tc, n_tc;
    logic       r_halt, n_halt;
    t_job       job;
    logic [7:0] idx;
    logic [8:0] op;
    logic       first;
    logic       bad;

    always_comb begin
        n_expect = r_expect; n_left = r_left; n_cmt = r_cmt; n_quo = r_quo;
        n_raw = r_raw; n_tc = r_tc; n_halt = r_halt;
        job = '0;
        idx = '0;
        op = opnd_idx(i_byte);
        first = 1'b0;
        bad = 1'b0;
        if (r_halt) begin
            job = '0;
        end else if (r_expect) begin
            n_cmt = 1'b0; n_quo = 1'b0; n_raw = 1'b0; n_tc = 2'd0;
            if (i_byte <= 8'd1) begin
                job.nl = 1'b1;
            end else begin
                n_left = i_byte - 8'd1;
                n_expect = 1'b0;
            end
        end else begin
            if (!i_byte[7] || r_cmt || r_quo || r_raw) begin
                if (i_byte < RAW_CODE) begin
                    job.sp_cnt = i_byte[3:0];
                end else if (i_byte == RAW_CODE) begin
                    n_raw = 1'b1;
                end else begin
                    job.lit_en = 1'b1;
                    job.lit_ch = i_byte;
                end
                if (i_byte == CH_SEMI) n_cmt = 1'b1;
                if (i_byte == CH_QUOTE) n_quo = !r_quo;
            end else begin
                if (r_tc != 2'd2) n_tc = r_tc + 2'd1;
                first = (n_tc == 2'd1);
                if (i_byte == SPACE_CODE) begin
                    idx = 8'(NUM_TOK - 1);
                end else if (first) begin
                    bad = (i_byte > FIRST_TOP);
                    idx = i_byte - FIRST_BASE;
                end else begin
                    bad = !op[8];
                    idx = op[7:0];
                end
                job.tok_en = 1'b1;
                job.tab_pre = first;
                job.tab_post = first;
            end
            if (bad) begin
                // unknown token: one error word, line stays open, halt
                job = '0;
                job.err = 1'b1;
                n_halt = 1'b1;
            end else begin
                if (r_left != 8'd0) n_left = r_left - 8'd1;
                if (n_left == 8'd0) begin
                    job.quo = n_quo;
                    job.nl = 1'b1;
                    n_expect = 1'b1;
                end
            end
        end
        o_load.load = i_accept && !job_empty(job);
        o_load.tok_idx = idx;
        o_load.job = job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect <= 1'b1; r_left <= '0; r_cmt <= 1'b0; r_quo <= 1'b0;
            r_raw <= 1'b0; r_tc <= 2'd0; r_halt <= 1'b0;
        end else if (i_accept) begin
            r_expect <= n_expect; r_left <= n_left; r_cmt <= n_cmt; r_quo <= n_quo;
            r_raw <= n_raw; r_tc <= n_tc; r_halt <= n_halt;
        end
    end

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt) else $error("halt cleared");
    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |-> !o_load.load) else $error("word after halt");
    a_tc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tc != 2'd3) else $error("token count overflow");

endmodule

// ===== design/detok_exp.sv =====
module detok_exp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  detok_pkg::t_load     i_load,
    output logic                 o_ready,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [7:0]           o_char,
    output logic                 o_error,
    output logic                 o_last
);
    import detok_pkg::*;

    localparam t_rom ROM = init_rom();

    logic       r_busy;
    t_job       r_job, n_job;
    logic [2:0] r_pos;
    t_ent       r_ent;
    logic [2:0] len;
    logic [2:0] sh;
    logic       fire;

    assign len = r_ent[58:56];
    assign sh  = len - 3'd1 - r_pos;

    always_comb begin
        n_job = r_job;
        o_char = '0;
        o_error = 1'b0;
        priority if (r_job.err) begin
            o_error = 1'b1; n_job.err = 1'b0;
        end else if (r_job.sp_cnt != 4'd0) begin
            o_char = CH_SPACE; n_job.sp_cnt = r_job.sp_cnt - 4'd1;
        end else if (r_job.lit_en) begin
            o_char = r_job.lit_ch; n_job.lit_en = 1'b0;
        end else if (r_job.tab_pre) begin
            o_char = CH_TAB; n_job.tab_pre = 1'b0;
        end else if (r_job.tok_en) begin
            o_char = r_ent[{sh, 3'b000} +: 8];
            if (r_pos + 3'd1 == len) n_job.tok_en = 1'b0;
        end else if (r_job.tab_post) begin
            o_char = CH_TAB; n_job.tab_post = 1'b0;
        end else if (r_job.quo) begin
            o_char = CH_QUOTE; n_job.quo = 1'b0;
        end else begin
            o_char = CH_NL; n_job.nl = 1'b0;
        end
    end

    assign o_valid = r_busy;
    assign o_last  = job_empty(n_job);
    assign fire    = r_busy && i_ready;
    // take the next byte while the last word of this one leaves
    assign o_ready = !r_busy || (fire && o_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_load.load) begin
            r_busy <= 1'b1;
        end else if (fire && o_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load.load) begin
            r_job <= i_load.job;
            r_pos <= 3'd0;
            r_ent <= ROM[i_load.tok_idx];
        end else if (fire) begin
            r_job <= n_job;
            if (!r_job.err && r_job.sp_cnt == 4'd0 && !r_job.lit_en && !r_job.tab_pre
                && r_job.tok_en) r_pos <= r_pos + 3'd1;
        end
    end

    a_busy_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !job_empty(r_job)) else $error("busy with empty job");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load.load |-> o_ready) else $error("job overwritten");
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_job.tok_en) |-> (r_pos < len)) else $error("token overrun");

endmodule
